// ----- sv/urlpd_pkg.sv -----
`default_nettype none
package urlpd_pkg;

    // ASCII codes used by the decoder
    localparam logic [7:0] CHR_PCT   = 8'h25;
    localparam logic [7:0] CHR_PLUS  = 8'h2B;
    localparam logic [7:0] CHR_SPACE = 8'h20;

    // Default depth of the group queue between front and back
    localparam int QUEUE_DEPTH_DEF = 4;

    // Escape phase states
    typedef enum logic [2:0] {
        PH_IDLE  = 3'b001,
        PH_PCT   = 3'b010,
        PH_DIGIT = 3'b100
    } t_phase;

    // Up to three decoded bytes caused by one request
    typedef struct packed {
        logic [2:0][7:0] data;
        logic [1:0]      cnt;
        logic            last;
    } t_group;

    // Hex digit check: {valid, nibble}
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        case (c) inside
            [8'h30:8'h39]: r = {1'b1, c[3:0]};
            [8'h41:8'h46],
            [8'h61:8'h66]: r = {1'b1, c[3:0] + 4'd9};
            default:       r = 5'd0;
        endcase
        return r;
    endfunction

    // Bytes that may stand in a URL unencoded
    function automatic logic url_safe(input logic [7:0] v);
        logic r;
        r = 1'b0;
        case (v) inside
            [8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A],
            8'h21, 8'h24, [8'h26:8'h2F],
            8'h3A, 8'h3B, 8'h3D, 8'h3F, 8'h40, 8'h5F: r = 1'b1;
            default: r = 1'b0;
        endcase
        return r;
    endfunction

    // Append one byte to a group; a full group stays as it is
    function automatic t_group put(input t_group g, input logic [7:0] b);
        t_group r;
        r = g;
        case (g.cnt)
            2'd0: begin
                r.data[0] = b;
                r.cnt = 2'd1;
            end
            2'd1: begin
                r.data[1] = b;
                r.cnt = 2'd2;
            end
            2'd2: begin
                r.data[2] = b;
                r.cnt = 2'd3;
            end
            default: r = g;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

// ----- sv/url_percent_decoder.sv -----
`default_nettype none
// Streaming URL percent decoder. Takes one encoded byte per cycle with a flag on the
// last byte and returns decoded bytes with the flag on the last one. Each input byte
// is decoded in the cycle it is accepted into a group of zero to three output bytes,
// which waits in a small queue (QUEUE_DEPTH groups); the output side sends one byte
// per cycle while i_out_ready is high. Plain bytes therefore flow at one per cycle in
// and out unless the output is held; a byte that yields two or three results holds
// the output until all are sent, and the input stalls only once the queue is full.
module url_percent_decoder #(
    parameter int QUEUE_DEPTH = urlpd_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire logic [7:0] i_in_byte,
    input  wire logic       i_in_end,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output logic [7:0]      o_out_byte,
    output logic            o_out_end
);
    import urlpd_pkg::*;

    t_group wr_grp, rd_grp;
    logic   push, pop, full, empty;

    urlpd_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_byte  (i_in_byte),
        .i_in_end   (i_in_end),
        .i_full     (full),
        .o_push     (push),
        .o_grp      (wr_grp)
    );

    urlpd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_wdata (wr_grp),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_rdata (rd_grp)
    );

    urlpd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (empty),
        .i_grp       (rd_grp),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_byte  (o_out_byte),
        .o_out_end   (o_out_end)
    );

endmodule
`default_nettype wire

// ----- sv/urlpd_front.sv -----
`default_nettype none
module urlpd_front (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_ready,
    input  wire logic [7:0]      i_in_byte,
    input  wire logic            i_in_end,
    input  wire logic            i_full,
    output logic                 o_push,
    output urlpd_pkg::t_group    o_grp
);
    import urlpd_pkg::*;

    t_phase     r_phase, n_phase;
    logic [7:0] r_held, n_held;
    logic       accept;

    assign o_in_ready = !i_full;
    assign accept     = i_in_valid && o_in_ready;
    assign o_push     = accept && (o_grp.cnt != 2'd0);

    // Classify the request and build its group of output bytes
    always_comb begin
        t_group     g;
        logic [4:0] lo;
        logic [4:0] hi;
        logic [7:0] v;
        logic [7:0] pb;
        logic       pct;
        g       = '0;
        lo      = hex_value(i_in_byte);
        hi      = hex_value(r_held);
        v       = {hi[3:0], lo[3:0]};
        pct     = (i_in_byte == CHR_PCT);
        pb      = (i_in_byte == CHR_PLUS) ? CHR_SPACE : i_in_byte;
        n_phase = PH_IDLE;
        n_held  = r_held;
        case (r_phase)
            PH_PCT: begin
                if (lo[4]) begin
                    n_held  = i_in_byte;
                    n_phase = PH_DIGIT;
                end else begin
                    g = put(g, CHR_PCT);
                    if (pct) n_phase = PH_PCT;
                    else     g = put(g, pb);
                end
            end
            PH_DIGIT: begin
                if (lo[4]) begin
                    if (!url_safe(v)) begin
                        g = put(g, v);
                    end else begin
                        g = put(g, CHR_PCT);
                        g = put(g, r_held);
                        g = put(g, i_in_byte);
                    end
                end else begin
                    g = put(g, CHR_PCT);
                    g = put(g, r_held);
                    if (pct) n_phase = PH_PCT;
                    else     g = put(g, pb);
                end
            end
            default: begin
                if (pct) n_phase = PH_PCT;
                else     g = put(g, pb);
            end
        endcase
        // Flush whatever is pending at the end of the string
        if (i_in_end) begin
            if (n_phase == PH_PCT) begin
                g = put(g, CHR_PCT);
            end else if (n_phase == PH_DIGIT) begin
                g = put(g, CHR_PCT);
                g = put(g, n_held);
            end
            n_phase = PH_IDLE;
            n_held  = 8'd0;
        end
        g.last = i_in_end;
        o_grp  = g;
    end

    // Advance escape state on each accepted request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_held  <= 8'd0;
        end else if (accept) begin
            r_phase <= n_phase;
            r_held  <= n_held;
        end
    end

endmodule
`default_nettype wire

// ----- sv/urlpd_queue.sv -----
`default_nettype none
module urlpd_queue #(
    parameter int DEPTH = urlpd_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire urlpd_pkg::t_group i_wdata,
    input  wire logic              i_pop,
    output logic                   o_full,
    output logic                   o_empty,
    output urlpd_pkg::t_group      o_rdata
);
    import urlpd_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_group             r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr, n_wr, r_rd, n_rd;
    logic [CNT_W-1:0]   r_cnt, n_cnt;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_rdata = r_mem[r_rd];

    // Advance pointers with wrap at the depth
    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) n_wr = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        if (i_pop)  n_rd = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        if (i_push && !i_pop)      n_cnt = r_cnt + 1'b1;
        else if (i_pop && !i_push) n_cnt = r_cnt - 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    // Store pushed groups
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_wdata;
    end

endmodule
`default_nettype wire

// ----- sv/urlpd_back.sv -----
`default_nettype none
module urlpd_back (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_empty,
    input  wire urlpd_pkg::t_group i_grp,
    output logic                   o_pop,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output logic [7:0]             o_out_byte,
    output logic                   o_out_end
);
    import urlpd_pkg::*;

    logic [1:0] r_idx, n_idx;
    logic       take;
    logic       tail;

    assign o_out_valid = !i_empty;
    assign take        = o_out_valid && i_out_ready;
    assign tail        = (r_idx == (i_grp.cnt - 2'd1));
    assign o_pop       = take && tail;
    assign o_out_byte  = i_grp.data[r_idx];
    assign o_out_end   = i_grp.last && tail;

    // Step through the bytes of the head group
    always_comb begin
        n_idx = r_idx;
        if (take) n_idx = tail ? 2'd0 : r_idx + 2'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_idx <= 2'd0;
        else          r_idx <= n_idx;
    end

endmodule
`default_nettype wire
